// ----- src/i2cw_pkg.sv -----
package i2cw_pkg;

  localparam int unsigned DelayWidthDefault = 16;

  localparam int unsigned AddrW    = 8;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned AckToW   = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [AddrW-1:0]  DevAddrReset  = 8'd120;
  localparam logic [HalfW-1:0]  HalfReset     = 16'd100;
  localparam logic [AckToW-1:0] AckToReset    = 8'd250;

  localparam logic [CfgIdxW-1:0] CfgDevAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHalf    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAckTo   = 2'd2;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] control_byte;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
    logic ack_error;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0]  device_address;
    logic [HalfW-1:0]  half_period_ticks;
    logic [AckToW-1:0] ack_timeout_ticks;
  } cfg_t;

endpackage

// ----- src/i2cw_seq.sv -----
module i2cw_seq #(
  parameter int unsigned DELAY_WIDTH = i2cw_pkg::DelayWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cw_pkg::in_item_t  item_i,
  input  i2cw_pkg::cfg_t      cfg_i,
  output i2cw_pkg::out_item_t res_o
);

  typedef enum logic [3:0] {
    PhIdle, PhStartA, PhStartB, PhBitLow, PhBitHigh, PhAckLow,
    PhAckHigh, PhAckPoll, PhStopA, PhStopB, PhStopC
  } phase_e;

  localparam int unsigned CmpW = ((DELAY_WIDTH > i2cw_pkg::HalfW) ?
                                  DELAY_WIDTH : i2cw_pkg::HalfW) + 1;

  phase_e                 phase_q, phase_d;
  logic [7:0]             shift_q, shift_d;
  logic [2:0]             bit_cnt_q, bit_cnt_d;
  logic [1:0]             byte_idx_q, byte_idx_d;
  logic [15:0]            pending_q, pending_d;
  logic [DELAY_WIDTH-1:0] delay_q, delay_d;
  logic [7:0]             ack_wait_q, ack_wait_d;
  logic                   err_q, err_d;

  logic                   hold_end;
  logic [CmpW-1:0]        hp_ext;
  logic [CmpW-1:0]        dly_inc;
  logic                   done;
  logic                   bitv;

  // hold ends when count+1 reaches the half period (zero read as one) or count saturates
  always_comb begin
    hp_ext   = CmpW'(cfg_i.half_period_ticks);
    if (cfg_i.half_period_ticks == '0) hp_ext = CmpW'(1);
    dly_inc  = CmpW'(delay_q) + CmpW'(1);
    hold_end = (dly_inc >= hp_ext) || (delay_q == {DELAY_WIDTH{1'b1}});
  end

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bit_cnt_d  = bit_cnt_q;
    byte_idx_d = byte_idx_q;
    pending_d  = pending_q;
    delay_d    = delay_q;
    ack_wait_d = ack_wait_q;
    err_d      = err_q;
    done       = 1'b0;

    if (item_i.req_type == i2cw_pkg::ReqStart) begin
      if (phase_q == PhIdle) begin
        pending_d  = {item_i.control_byte, item_i.data_byte};
        shift_d    = cfg_i.device_address;
        bit_cnt_d  = '0;
        byte_idx_d = '0;
        ack_wait_d = '0;
        err_d      = 1'b0;
        phase_d    = PhStartA;
        delay_d    = '0;
      end
    end else if (phase_q != PhIdle) begin
      // timed phases: count or move on
      if (phase_q != PhAckPoll) begin
        if (hold_end) delay_d = '0;
        else          delay_d = delay_q + DELAY_WIDTH'(1);
      end
      case (phase_q)
        PhStartA:  if (hold_end) phase_d = PhStartB;
        PhStartB:  if (hold_end) phase_d = PhBitLow;
        PhBitLow:  if (hold_end) phase_d = PhBitHigh;
        PhBitHigh: begin
          if (hold_end) begin
            shift_d = {shift_q[6:0], 1'b0};
            if (bit_cnt_q == 3'd7) begin
              bit_cnt_d = '0;
              phase_d   = PhAckLow;
            end else begin
              bit_cnt_d = bit_cnt_q + 3'd1;
              phase_d   = PhBitLow;
            end
          end
        end
        PhAckLow:  if (hold_end) phase_d = PhAckHigh;
        PhAckHigh: begin
          if (hold_end) begin
            ack_wait_d = '0;
            phase_d    = PhAckPoll;
          end
        end
        PhAckPoll: begin
          if (!item_i.sda_in) begin
            delay_d = '0;
            if (byte_idx_q == 2'd0) begin
              byte_idx_d = 2'd1;
              shift_d    = pending_q[15:8];
              phase_d    = PhBitLow;
            end else if (byte_idx_q == 2'd1) begin
              byte_idx_d = 2'd2;
              shift_d    = pending_q[7:0];
              phase_d    = PhBitLow;
            end else begin
              phase_d = PhStopA;
            end
          end else if (ack_wait_q >= cfg_i.ack_timeout_ticks) begin
            err_d   = 1'b1;
            delay_d = '0;
            phase_d = PhStopA;
          end else begin
            ack_wait_d = ack_wait_q + 8'd1;
          end
        end
        PhStopA:   if (hold_end) phase_d = PhStopB;
        PhStopB:   if (hold_end) phase_d = PhStopC;
        PhStopC: begin
          if (hold_end) begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = PhIdle;
          delay_d = '0;
        end
      endcase
    end
  end

  // line levels follow the new phase
  always_comb begin
    bitv            = shift_d[7];
    res_o.scl_level = 1'b1;
    res_o.sda_level = 1'b1;
    case (phase_d)
      PhStartB:  begin res_o.scl_level = 1'b1; res_o.sda_level = 1'b0; end
      PhBitLow:  begin res_o.scl_level = 1'b0; res_o.sda_level = bitv; end
      PhBitHigh: begin res_o.scl_level = 1'b1; res_o.sda_level = bitv; end
      PhAckLow:  begin res_o.scl_level = 1'b0; res_o.sda_level = 1'b1; end
      PhStopA:   begin res_o.scl_level = 1'b0; res_o.sda_level = 1'b0; end
      PhStopB:   begin res_o.scl_level = 1'b1; res_o.sda_level = 1'b0; end
      default:   begin res_o.scl_level = 1'b1; res_o.sda_level = 1'b1; end
    endcase
    res_o.busy_res  = (phase_d != PhIdle);
    res_o.done_res  = done;
    res_o.ack_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      shift_q    <= '0;
      bit_cnt_q  <= '0;
      byte_idx_q <= '0;
      pending_q  <= '0;
      delay_q    <= '0;
      ack_wait_q <= '0;
      err_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      shift_q    <= shift_d;
      bit_cnt_q  <= bit_cnt_d;
      byte_idx_q <= byte_idx_d;
      pending_q  <= pending_d;
      delay_q    <= delay_d;
      ack_wait_q <= ack_wait_d;
      err_q      <= err_d;
    end
  end

endmodule

// ----- src/i2c_three_byte_write_master.sv -----
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o   i2cw_pkg::in_item_t (start request or tick)
// out       output     out_valid_o / out_stall_i i2cw_pkg::out_item_t (line levels, status)
// cfg       input      cfg_we_i, cfg_idx_i       cfg_data_i (address, half period, ack timeout)
//
// One item per cycle unless stalled: each accepted item yields one result the next cycle.
// The sequencer state and the result register are the only stages; the
// result register is the sole buffer between the two sides.
// Reset (rst_ni low, asynchronous) returns the bus to idle with config registers at defaults.
// A stalled result holds; the input is stalled only while a result waits.
module i2c_three_byte_write_master #(
  parameter int unsigned DELAY_WIDTH = i2cw_pkg::DelayWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  i2cw_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output i2cw_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [i2cw_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [i2cw_pkg::CfgDataW-1:0]   cfg_data_i
);

  i2cw_pkg::cfg_t      cfg_q;
  i2cw_pkg::out_item_t res_d;
  i2cw_pkg::out_item_t res_q;
  logic                out_valid_q;
  logic                accept;

  // a new item may come in whenever the result slot is empty or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // configuration registers; out-of-range indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= i2cw_pkg::DevAddrReset;
      cfg_q.half_period_ticks <= i2cw_pkg::HalfReset;
      cfg_q.ack_timeout_ticks <= i2cw_pkg::AckToReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cw_pkg::CfgDevAddr: cfg_q.device_address    <= cfg_data_i[i2cw_pkg::AddrW-1:0];
        i2cw_pkg::CfgHalf:    cfg_q.half_period_ticks <= cfg_data_i[i2cw_pkg::HalfW-1:0];
        i2cw_pkg::CfgAckTo:   cfg_q.ack_timeout_ticks <= cfg_data_i[i2cw_pkg::AckToW-1:0];
        default: ;
      endcase
    end
  end

  // bus sequencer: one time step per accepted item
  i2cw_seq #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule
